### rtl/bmft_pkg.sv
`default_nettype none

package bmft_pkg;

   // Geometry
   localparam int SECTORS_PER_BLOCK = 32;
   localparam int DATA_BLOCKS       = 64;
   localparam int OFF_W             = $clog2(SECTORS_PER_BLOCK);
   localparam int LB_W              = $clog2(DATA_BLOCKS);
   localparam int BLK_W             = $clog2(DATA_BLOCKS + 1);
   localparam int ROWS              = DATA_BLOCKS + 1;
   localparam int LSEC_W            = LB_W + OFF_W;
   localparam int PSEC_W            = BLK_W + OFF_W;
   localparam logic [BLK_W-1:0] SPARE_BLK = BLK_W'(DATA_BLOCKS);

   // Result command codes
   typedef enum logic [2:0] {
      CMD_READ    = 3'd0,
      CMD_COPY    = 3'd1,
      CMD_ERASE   = 3'd2,
      CMD_PROGRAM = 3'd3,
      CMD_NOFREE  = 3'd4
   } cmd_type;

   // Request and response payloads
   typedef struct packed {
      logic              operation;
      logic [LSEC_W-1:0] logical_sector;
   } req_type;

   typedef struct packed {
      cmd_type           command;
      logic [PSEC_W-1:0] target_sector;
      logic [PSEC_W-1:0] source_sector;
      logic [BLK_W-1:0]  erased_block;
      logic              holds_data;
      logic              last;
   } rsp_type;

   // Source of the validity row read address
   typedef enum logic [1:0] {
      RS_PB,
      RS_SPARE,
      RS_LAST,
      RS_CAND_DEC
   } rsel_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP,
      ST_ROW,
      ST_DECIDE,
      ST_SPARE,
      ST_SEARCH,
      ST_NOFREE,
      ST_COPY,
      ST_ERASE,
      ST_PROG
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic     accept;
      logic     pb_load;
      logic     src_load;
      rsel_type row_sel;
      logic     cand_from_last;
      logic     cand_dec;
      logic     dest_from_spare;
      logic     dest_from_cand;
      logic     idx_clear;
      logic     idx_inc;
      logic     emit;
      cmd_type  emit_cmd;
      logic     emit_last;
      logic     commit_prog;
      logic     commit_erase;
   } ctrl_type;

   // Datapath to controller
   typedef struct packed {
      logic op_write;
      logic sector_used;
      logic row_empty;
      logic last_ok;
      logic cand_at_one;
      logic copy_hit;
      logic idx_at_end;
      logic slot_free;
   } status_type;

endpackage

`default_nettype wire

### rtl/block_mapped_flash_translation.sv
// Block-mapped flash translation: each request reads or writes one logical
// sector and produces a short series of flash commands on the response
// channel, the final one flagged last. Requests are handled one at a time.
// A read, or a write to an empty sector, passes through the map lookup, the
// validity row read and the decision before its single response. A write
// to a used sector merges the block: it takes the spare block if empty,
// else searches down from the last erased block for a free one (failing
// that, a no-free response ends it), copies each other used sector of the
// old block, then issues the erase and the program. Validity memory gives
// one block row per cycle; the offsets are walked one per cycle unless a
// copy waits on a stalled response. After reset the block is ready at once.
`default_nettype none

module block_mapped_flash_translation (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire bmft_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output bmft_pkg::rsp_type      rsp_data
);

   bmft_pkg::ctrl_type   ctl;
   bmft_pkg::status_type sts;

   // Sequencer
   bmft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // Map, validity rows and response register
   bmft_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/bmft_ctrl.sv
`default_nettype none

module bmft_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire bmft_pkg::status_type sts,
   output bmft_pkg::ctrl_type       ctl
);

   bmft_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmft_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bmft_pkg::ST_IDLE: begin
            if (req_valid) state_in = bmft_pkg::ST_MAP;
         end
         bmft_pkg::ST_MAP:  state_in = bmft_pkg::ST_ROW;
         bmft_pkg::ST_ROW:  state_in = bmft_pkg::ST_DECIDE;
         bmft_pkg::ST_DECIDE: begin
            if (sts.op_write && sts.sector_used) begin
               state_in = bmft_pkg::ST_SPARE;
            end else if (sts.slot_free) begin
               state_in = bmft_pkg::ST_IDLE;
            end
         end
         bmft_pkg::ST_SPARE: begin
            if (sts.row_empty)    state_in = bmft_pkg::ST_COPY;
            else if (sts.last_ok) state_in = bmft_pkg::ST_SEARCH;
            else                  state_in = bmft_pkg::ST_NOFREE;
         end
         bmft_pkg::ST_SEARCH: begin
            if (sts.row_empty)        state_in = bmft_pkg::ST_COPY;
            else if (sts.cand_at_one) state_in = bmft_pkg::ST_NOFREE;
         end
         bmft_pkg::ST_NOFREE: begin
            if (sts.slot_free) state_in = bmft_pkg::ST_IDLE;
         end
         bmft_pkg::ST_COPY: begin
            if ((!sts.copy_hit || sts.slot_free) && sts.idx_at_end) begin
               state_in = bmft_pkg::ST_ERASE;
            end
         end
         bmft_pkg::ST_ERASE: begin
            if (sts.slot_free) state_in = bmft_pkg::ST_PROG;
         end
         bmft_pkg::ST_PROG: begin
            if (sts.slot_free) state_in = bmft_pkg::ST_IDLE;
         end
         default: state_in = bmft_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      ctl       = '0;
      ctl.row_sel = bmft_pkg::RS_SPARE;
      ctl.emit_cmd = bmft_pkg::CMD_READ;
      req_stall = 1'b1;
      case (state_ff)
         bmft_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            ctl.accept = req_valid;
         end
         bmft_pkg::ST_MAP: begin
            ctl.pb_load = 1'b1;
            ctl.row_sel = bmft_pkg::RS_PB;
         end
         bmft_pkg::ST_ROW: begin
            ctl.src_load = 1'b1;
         end
         bmft_pkg::ST_DECIDE: begin
            ctl.idx_clear = 1'b1;
            if (!sts.op_write) begin
               ctl.emit      = sts.slot_free;
               ctl.emit_cmd  = bmft_pkg::CMD_READ;
               ctl.emit_last = 1'b1;
            end else if (!sts.sector_used) begin
               ctl.emit        = sts.slot_free;
               ctl.emit_cmd    = bmft_pkg::CMD_PROGRAM;
               ctl.emit_last   = 1'b1;
               ctl.commit_prog = sts.slot_free;
            end
         end
         bmft_pkg::ST_SPARE: begin
            ctl.row_sel = bmft_pkg::RS_LAST;
            if (sts.row_empty) begin
               ctl.dest_from_spare = 1'b1;
            end else begin
               ctl.cand_from_last = 1'b1;
            end
         end
         bmft_pkg::ST_SEARCH: begin
            ctl.row_sel = bmft_pkg::RS_CAND_DEC;
            if (sts.row_empty) begin
               ctl.dest_from_cand = 1'b1;
            end else begin
               ctl.cand_dec = 1'b1;
            end
         end
         bmft_pkg::ST_NOFREE: begin
            ctl.emit      = sts.slot_free;
            ctl.emit_cmd  = bmft_pkg::CMD_NOFREE;
            ctl.emit_last = 1'b1;
         end
         bmft_pkg::ST_COPY: begin
            ctl.emit_cmd = bmft_pkg::CMD_COPY;
            ctl.emit     = sts.copy_hit && sts.slot_free;
            ctl.idx_inc  = !sts.copy_hit || sts.slot_free;
         end
         bmft_pkg::ST_ERASE: begin
            ctl.emit_cmd     = bmft_pkg::CMD_ERASE;
            ctl.emit         = sts.slot_free;
            ctl.commit_erase = sts.slot_free;
         end
         bmft_pkg::ST_PROG: begin
            ctl.emit_cmd    = bmft_pkg::CMD_PROGRAM;
            ctl.emit_last   = 1'b1;
            ctl.emit        = sts.slot_free;
            ctl.commit_prog = sts.slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/bmft_dp.sv
`default_nettype none

module bmft_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bmft_pkg::req_type    req_data,
   input  wire bmft_pkg::ctrl_type   ctl,
   output bmft_pkg::status_type      sts,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output bmft_pkg::rsp_type         rsp_data
);

   localparam int OFF_W = bmft_pkg::OFF_W;
   localparam int LB_W  = bmft_pkg::LB_W;
   localparam int BLK_W = bmft_pkg::BLK_W;
   localparam int SPB   = bmft_pkg::SECTORS_PER_BLOCK;
   localparam int DBLK  = bmft_pkg::DATA_BLOCKS;
   localparam int ROWS  = bmft_pkg::ROWS;

   // Request registers
   logic             op_ff;
   logic [LB_W-1:0]  lb_ff;
   logic [OFF_W-1:0] off_ff;
   logic [BLK_W-1:0] pb_ff, dest_ff, cand_ff;
   logic [OFF_W-1:0] idx_ff;
   logic [SPB-1:0]   src_row_ff;
   logic [BLK_W-1:0] last_erased_ff;

   // Block map memory, entries not yet written read as the reversed order
   logic [BLK_W-1:0] map_mem [0:DBLK-1];
   logic [BLK_W-1:0] map_q_ff;
   logic [DBLK-1:0]  map_vld_ff;
   logic [BLK_W-1:0] map_blk;

   // Sector validity, one row per physical block; unwritten rows read as empty
   logic [SPB-1:0]   row_mem [0:ROWS-1];
   logic [SPB-1:0]   row_q_ff;
   logic [BLK_W-1:0] row_addr_ff;
   logic [ROWS-1:0]  row_vld_ff;
   logic [BLK_W-1:0] row_rd_addr;
   logic [SPB-1:0]   row_data;
   logic [SPB-1:0]   prog_row;

   logic             rsp_valid_ff;
   bmft_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [LB_W-1:0]  req_lb;

   assign req_lb = req_data.logical_sector[OFF_W +: LB_W];

   // Latch the request fields
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         op_ff  <= req_data.operation;
         lb_ff  <= req_lb;
         off_ff <= req_data.logical_sector[OFF_W-1:0];
      end
   end

   // Map read, write on commit
   always_ff @(posedge clock) begin
      if (ctl.commit_prog) map_mem[lb_ff] <= dest_ff;
      map_q_ff <= map_mem[req_lb];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_vld_ff <= '0;
      end else if (ctl.commit_prog) begin
         map_vld_ff[lb_ff] <= 1'b1;
      end
   end

   assign map_blk = map_vld_ff[lb_ff] ? map_q_ff
                                      : BLK_W'(DBLK - 1) - BLK_W'(lb_ff);

   // Row read address
   always_comb begin
      case (ctl.row_sel)
         bmft_pkg::RS_PB:       row_rd_addr = map_blk;
         bmft_pkg::RS_SPARE:    row_rd_addr = bmft_pkg::SPARE_BLK;
         bmft_pkg::RS_LAST:     row_rd_addr = last_erased_ff;
         bmft_pkg::RS_CAND_DEC: row_rd_addr = cand_ff - BLK_W'(1);
         default:               row_rd_addr = bmft_pkg::SPARE_BLK;
      endcase
   end

   assign prog_row = src_row_ff | (SPB'(1) << off_ff);

   // Validity rows: program writes the destination row
   always_ff @(posedge clock) begin
      if (ctl.commit_prog) row_mem[dest_ff] <= prog_row;
      row_q_ff    <= row_mem[row_rd_addr];
      row_addr_ff <= row_rd_addr;
   end

   // Row valid bits: erase drops the row, program marks it written
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else begin
         if (ctl.commit_erase) row_vld_ff[pb_ff] <= 1'b0;
         if (ctl.commit_prog)  row_vld_ff[dest_ff] <= 1'b1;
      end
   end

   assign row_data = row_vld_ff[row_addr_ff] ? row_q_ff : '0;

   // Block registers
   always_ff @(posedge clock) begin
      if (ctl.pb_load) begin
         pb_ff   <= map_blk;
         dest_ff <= map_blk;
      end else if (ctl.dest_from_spare) begin
         dest_ff <= bmft_pkg::SPARE_BLK;
      end else if (ctl.dest_from_cand) begin
         dest_ff <= cand_ff;
      end
      if (ctl.src_load) src_row_ff <= row_data;
      if (ctl.cand_from_last) begin
         cand_ff <= last_erased_ff;
      end else if (ctl.cand_dec) begin
         cand_ff <= cand_ff - BLK_W'(1);
      end
      if (ctl.idx_clear) begin
         idx_ff <= '0;
      end else if (ctl.idx_inc) begin
         idx_ff <= idx_ff + OFF_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_erased_ff <= '0;
      end else if (ctl.commit_erase) begin
         last_erased_ff <= pb_ff;
      end
   end

   // Status
   assign sts.op_write    = op_ff;
   assign sts.sector_used = src_row_ff[off_ff];
   assign sts.row_empty   = (row_data == '0);
   assign sts.last_ok     = (last_erased_ff < bmft_pkg::SPARE_BLK) && (last_erased_ff != '0);
   assign sts.cand_at_one = (cand_ff == BLK_W'(1));
   assign sts.copy_hit    = src_row_ff[idx_ff] && (idx_ff != off_ff);
   assign sts.idx_at_end  = (idx_ff == OFF_W'(SPB - 1));
   assign sts.slot_free   = !rsp_valid_ff || !rsp_stall;

   // Response payload
   always_comb begin
      rsp_data_in          = '0;
      rsp_data_in.command  = ctl.emit_cmd;
      rsp_data_in.last     = ctl.emit_last;
      case (ctl.emit_cmd)
         bmft_pkg::CMD_READ: begin
            rsp_data_in.target_sector = {pb_ff, off_ff};
            rsp_data_in.holds_data    = src_row_ff[off_ff];
         end
         bmft_pkg::CMD_COPY: begin
            rsp_data_in.target_sector = {dest_ff, idx_ff};
            rsp_data_in.source_sector = {pb_ff, idx_ff};
         end
         bmft_pkg::CMD_ERASE: begin
            rsp_data_in.erased_block = pb_ff;
         end
         bmft_pkg::CMD_PROGRAM: begin
            rsp_data_in.target_sector = {dest_ff, off_ff};
         end
         default: begin
            rsp_data_in.holds_data = 1'b0;
         end
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/bmft_checker.sv
`default_nettype none

module bmft_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire bmft_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire bmft_pkg::rsp_type rsp_data
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // One request at a time: busy right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   // Read and no-free responses end their request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.command == bmft_pkg::CMD_READ ||
                    rsp_data.command == bmft_pkg::CMD_NOFREE) |-> rsp_data.last)
      else $error("single response not flagged last");

   // Copy and erase never end a request
   a_merge_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.command == bmft_pkg::CMD_COPY ||
                    rsp_data.command == bmft_pkg::CMD_ERASE) |-> !rsp_data.last)
      else $error("merge step flagged last");

endmodule

bind block_mapped_flash_translation bmft_checker u_bmft_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
